FILE: design/gfr_pkg.sv
package gfr_pkg;

    localparam int RPM_W   = 16;
    localparam int KMH_W   = 8;
    localparam int SCALE_W = 16;
    localparam int RATIO_W = 16;
    localparam int GEAR_W  = 4;
    localparam int RC_W    = 3;
    localparam int ENTRY_W = 36;
    localparam int DEN_W   = KMH_W + SCALE_W;
    localparam int CFG_AW  = 3;
    localparam int DIV_STEPS = RATIO_W;
    localparam int DCNT_W  = $clog2(DIV_STEPS);

    localparam logic [CFG_AW-1:0] REG_RANGE_COUNT = 3'd0;
    localparam logic [CFG_AW-1:0] REG_RATIO_SCALE = 3'd1;
    localparam logic [CFG_AW-1:0] REG_ENTRY_BASE  = 3'd2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
    localparam logic [RPM_W-1:0]   IDLE_RPM    = 16'd800;
    localparam logic [KMH_W-1:0]   CREEP_KMH   = 8'd5;
    localparam logic [GEAR_W-1:0]  NEUTRAL_CODE = 4'd0;

    typedef enum logic [1:0] {
        DEC_ZERO  = 2'd0,
        DEC_MATCH = 2'd1,
        DEC_IDLE  = 2'd2,
        DEC_HELD  = 2'd3
    } t_decision;

    typedef struct packed {
        logic load_in;
        logic load_den;
        logic div_init;
        logic div_step;
        logic scan_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_zero;
        logic sat;
        logic div_last;
        logic scan_done;
    } t_status;

endpackage

FILE: design/gfr_ctrl.sv
module gfr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  gfr_pkg::t_status i_status,
    output gfr_pkg::t_cmd    o_cmd
);
    import gfr_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_PREP = 6'b000100,
        S_DIV  = 6'b001000,
        S_SCAN = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.load_den = 1'b1;
                n_state        = S_PREP;
            end
            S_PREP: begin
                o_cmd.div_init = 1'b1;
                if (i_status.in_zero) begin
                    n_state = S_OUT;
                end else if (i_status.sat) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: design/gfr_dpath.sv
module gfr_dpath #(
    parameter int MAX_RANGES = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gfr_pkg::t_cmd                i_cmd,
    output gfr_pkg::t_status             o_status,
    input  logic [gfr_pkg::RPM_W-1:0]    i_engine_rpm,
    input  logic [gfr_pkg::KMH_W-1:0]    i_vehicle_kmh,
    input  logic [gfr_pkg::RC_W-1:0]     i_range_count,
    input  logic [gfr_pkg::SCALE_W-1:0]  i_ratio_scale,
    input  logic [gfr_pkg::ENTRY_W-1:0]  i_entries [MAX_RANGES],
    output logic [gfr_pkg::GEAR_W-1:0]   o_gear_code,
    output logic [1:0]                   o_decision,
    output logic [gfr_pkg::RATIO_W-1:0]  o_ratio_q8
);
    import gfr_pkg::*;

    localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

    logic [RPM_W-1:0]   r_rpm;
    logic [KMH_W-1:0]   r_kmh;
    logic [DEN_W-1:0]   r_den;
    logic [DEN_W-1:0]   r_rem;
    logic [RATIO_W-1:0] r_quo;
    logic [DCNT_W-1:0]  r_cnt;
    logic [IDX_W-1:0]   r_idx;
    logic               r_hit;
    logic [GEAR_W-1:0]  r_hit_gear;
    logic [GEAR_W-1:0]  r_last_gear;
    logic [GEAR_W-1:0]  r_gear_out;
    logic [1:0]         r_dec_out;
    logic [RATIO_W-1:0] r_ratio_out;

    logic [DEN_W-1:0]   w_prod;
    logic               w_in_zero;
    logic               w_sat;
    logic [DEN_W:0]     w_shift;
    logic               w_fits;
    logic [RC_W-1:0]    w_limit;
    logic               w_in_list;
    logic [ENTRY_W-1:0] w_entry;
    logic [RATIO_W-1:0] w_lo;
    logic [RATIO_W-1:0] w_hi;
    logic               w_match;
    logic               w_idle_rule;
    logic [GEAR_W-1:0]  w_gear;
    t_decision          w_dec;
    logic [RATIO_W-1:0] w_ratio;

    assign w_prod    = DEN_W'(r_kmh) * DEN_W'(i_ratio_scale);
    assign w_in_zero = (r_rpm == '0) || (r_kmh == '0);
    assign w_sat     = (r_den == '0) || (DEN_W'(r_rpm) >= r_den);
    assign w_shift   = {r_rem, 1'b0};
    assign w_fits    = (w_shift >= {1'b0, r_den});

    assign w_limit   = (i_range_count > RC_W'(MAX_RANGES)) ? RC_W'(MAX_RANGES) : i_range_count;
    assign w_in_list = (RC_W'(r_idx) < w_limit);
    assign w_entry   = w_in_list ? i_entries[r_idx] : '0;
    assign w_lo      = w_entry[35:20];
    assign w_hi      = w_entry[19:4];
    assign w_match   = w_in_list && (r_quo >= w_lo) && (r_quo <= w_hi);

    assign w_idle_rule = (r_rpm > IDLE_RPM) && (r_kmh < CREEP_KMH);

    assign o_status.in_zero   = w_in_zero;
    assign o_status.sat       = w_sat;
    assign o_status.div_last  = (r_cnt == DCNT_W'(DIV_STEPS - 1));
    assign o_status.scan_done = w_match || ((RC_W'(r_idx) + RC_W'(1)) >= w_limit);

    always_comb begin
        if (w_in_zero) begin
            w_gear  = NEUTRAL_CODE;
            w_dec   = DEC_ZERO;
            w_ratio = '0;
        end else if (r_hit) begin
            w_gear  = r_hit_gear;
            w_dec   = DEC_MATCH;
            w_ratio = r_quo;
        end else if (w_idle_rule) begin
            w_gear  = NEUTRAL_CODE;
            w_dec   = DEC_IDLE;
            w_ratio = r_quo;
        end else begin
            w_gear  = r_last_gear;
            w_dec   = DEC_HELD;
            w_ratio = r_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_rpm <= i_engine_rpm;
            r_kmh <= i_vehicle_kmh;
        end
        if (i_cmd.load_den) begin
            r_den <= w_prod;
        end
        if (i_cmd.div_init) begin
            r_rem <= DEN_W'(r_rpm);
            r_quo <= w_sat ? '1 : '0;
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_cmd.div_step) begin
            if (w_fits) begin
                r_rem <= DEN_W'(w_shift - {1'b0, r_den});
                r_quo <= {r_quo[RATIO_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[DEN_W-1:0];
                r_quo <= {r_quo[RATIO_W-2:0], 1'b0};
            end
            r_cnt <= r_cnt + DCNT_W'(1);
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + IDX_W'(1);
            if (w_match) begin
                r_hit_gear <= w_entry[3:0];
            end
        end
        if (i_cmd.out_load) begin
            r_gear_out  <= w_gear;
            r_dec_out   <= w_dec;
            r_ratio_out <= w_ratio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit       <= 1'b0;
            r_last_gear <= NEUTRAL_CODE;
        end else begin
            if (i_cmd.div_init) begin
                r_hit <= 1'b0;
            end else if (i_cmd.scan_step && w_match) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_last_gear <= w_gear;
            end
        end
    end

    assign o_gear_code = r_gear_out;
    assign o_decision  = r_dec_out;
    assign o_ratio_q8  = r_ratio_out;

endmodule

FILE: design/gear_from_ratio_estimator.sv
// Estimates the gear from one engine speed and vehicle speed pair per transfer. The ratio
// engine_rpm * 65536 / (vehicle_kmh * ratio_scale) is formed by a restoring divider that
// produces one quotient bit per cycle, then the configured ranges are checked one entry per
// cycle, from the first entry up to the first match (at least one entry, at most MAX_RANGES).
// A ratio that saturates skips the divider and goes straight to the range scan, and an item
// with a zero speed skips both the divider and the scan. The input is ready again in the same
// cycle that the result appears. The result sits in an output register, so the next item is
// accepted while the previous result waits; that next item stalls before its result only if
// the previous one has still not been taken.
module gear_from_ratio_estimator #(
    parameter int MAX_RANGES = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [gfr_pkg::RPM_W-1:0]    i_engine_rpm,
    input  logic [gfr_pkg::KMH_W-1:0]    i_vehicle_kmh,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [gfr_pkg::GEAR_W-1:0]   o_gear_code,
    output logic [1:0]                   o_decision,
    output logic [gfr_pkg::RATIO_W-1:0]  o_ratio_q8,
    input  logic                         i_cfg_we,
    input  logic [gfr_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [gfr_pkg::ENTRY_W-1:0]  i_cfg_wdata
);
    import gfr_pkg::*;

    logic [RC_W-1:0]    r_range_count;
    logic [SCALE_W-1:0] r_ratio_scale;
    logic [ENTRY_W-1:0] r_entry [MAX_RANGES];
    t_cmd               w_cmd;
    t_status            w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_count <= '0;
            r_ratio_scale <= SCALE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == REG_RANGE_COUNT) begin
                r_range_count <= i_cfg_wdata[RC_W-1:0];
            end else if (i_cfg_addr == REG_RATIO_SCALE) begin
                r_ratio_scale <= i_cfg_wdata[SCALE_W-1:0];
            end
        end
    end

    for (genvar g = 0; g < MAX_RANGES; g++) begin : g_entry
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_entry[g] <= '0;
            end else if (i_cfg_we && (i_cfg_addr == CFG_AW'(REG_ENTRY_BASE + g))) begin
                r_entry[g] <= i_cfg_wdata;
            end
        end
    end

    gfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    gfr_dpath #(
        .MAX_RANGES (MAX_RANGES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_engine_rpm  (i_engine_rpm),
        .i_vehicle_kmh (i_vehicle_kmh),
        .i_range_count (r_range_count),
        .i_ratio_scale (r_ratio_scale),
        .i_entries     (r_entry),
        .o_gear_code   (o_gear_code),
        .o_decision    (o_decision),
        .o_ratio_q8    (o_ratio_q8)
    );

`ifndef SYNTHESIS
    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted again while an item was in progress");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_decision == DEC_ZERO))
            |-> ((o_ratio_q8 == '0) && (o_gear_code == NEUTRAL_CODE)))
        else $error("zero-input result carries a nonzero ratio or gear");

    a_idle_neutral: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_decision == DEC_IDLE)) |-> (o_gear_code == NEUTRAL_CODE))
        else $error("idle rule result is not neutral");

    a_result_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_out_valid)
        else $error("result register loaded without raising valid");
`endif

endmodule
